// ----- rtl/hhlp_pkg.sv -----
// Shared types and constants for the HTTP header line parser.
package hhlp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 12;

  localparam logic [ByteW-1:0]   ChCr    = 8'h0D;
  localparam logic [ByteW-1:0]   ChLf    = 8'h0A;
  localparam logic [ByteW-1:0]   ChColon = 8'h3A;
  localparam logic [ByteW-1:0]   ChSpace = 8'h20;
  localparam logic [OffsetW-1:0] OffsetMax    = {OffsetW{1'b1}};
  localparam logic [OffsetW-1:0] MaxOffsetRst = 12'd255;

  typedef enum logic [1:0] {
    ROLE_SEP   = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_VALUE = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_KEY_BRK  = 3'd1,
    ERR_NO_SPACE = 3'd2,
    ERR_VAL_LONG = 3'd3,
    ERR_CR_NO_LF = 3'd4
  } err_e;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    role_e            role;
    logic             key_done;
    logic             line_done;
    logic             headers_done;
    err_e             err_code;
  } hhlp_res_t;

endpackage

// ----- rtl/hhlp_if.sv -----
// Stream and configuration channel interfaces of the header line parser.
interface hhlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       restart;

  modport source (output valid, output byte_in, output restart, input ready);
  modport sink (input valid, input byte_in, input restart, output ready);
endinterface

interface hhlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] role;
  logic       key_done;
  logic       line_done;
  logic       headers_done;
  logic       error;
  logic [2:0] error_code;

  modport source (
    output valid, output byte_out, output role, output key_done, output line_done,
    output headers_done, output error, output error_code, input ready
  );
  modport sink (
    input valid, input byte_out, input role, input key_done, input line_done,
    input headers_done, input error, input error_code, output ready
  );
endinterface

interface hhlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/hhlp_parser.sv -----
// Header line state machine: tags one byte per advance and tracks sticky errors.
module hhlp_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [hhlp_pkg::ByteW-1:0]   byte_i,
  input  logic                         restart_i,
  input  logic [hhlp_pkg::OffsetW-1:0] max_off_i,
  output hhlp_pkg::hhlp_res_t          res_o
);
  import hhlp_pkg::*;

  typedef enum logic [3:0] {
    S_START  = 4'd0,
    S_KEY    = 4'd1,
    S_COLON  = 4'd2,
    S_SPACE  = 4'd3,
    S_VALUE  = 4'd4,
    S_CR     = 4'd5,
    S_LF     = 4'd6,
    S_END_CR = 4'd7
  } state_e;

  state_e             state_q, state_d, state_cur;
  logic [OffsetW-1:0] off_q, off_d, off_cur;
  err_e               err_q, err_d, err_cur;
  logic [OffsetW:0]   off_inc;
  logic               too_long;

  assign state_cur = restart_i ? S_START : state_q;
  assign off_cur   = restart_i ? '0 : off_q;
  assign err_cur   = restart_i ? ERR_NONE : err_q;
  assign off_inc   = {1'b0, off_cur} + {{OffsetW{1'b0}}, 1'b1};
  assign too_long  = off_inc > {1'b0, max_off_i};

  always_comb begin
    state_d            = state_cur;
    off_d              = off_cur;
    err_d              = err_cur;
    res_o.byte_out     = byte_i;
    res_o.role         = ROLE_SEP;
    res_o.key_done     = 1'b0;
    res_o.line_done    = 1'b0;
    res_o.headers_done = 1'b0;
    if (err_cur == ERR_NONE) begin
      case (state_cur)
        S_KEY: begin
          if (byte_i == ChColon) begin
            res_o.key_done = 1'b1;
            state_d        = S_COLON;
          end else if (byte_i == ChCr || byte_i == ChLf) begin
            err_d = ERR_KEY_BRK;
          end else begin
            res_o.role = ROLE_KEY;
          end
        end
        S_COLON: begin
          if (byte_i == ChSpace) begin
            state_d = S_SPACE;
          end else begin
            err_d = ERR_NO_SPACE;
          end
        end
        S_SPACE: begin
          res_o.role = ROLE_VALUE;
          off_d      = '0;
          state_d    = S_VALUE;
        end
        S_VALUE: begin
          if (byte_i == ChCr) begin
            state_d = S_CR;
          end else begin
            if (too_long) begin
              err_d = ERR_VAL_LONG;
            end else begin
              res_o.role = ROLE_VALUE;
            end
            off_d = off_inc[OffsetW] ? OffsetMax : off_inc[OffsetW-1:0];
          end
        end
        S_CR: begin
          if (byte_i == ChLf) begin
            res_o.line_done = 1'b1;
            state_d         = S_LF;
          end else begin
            err_d = ERR_CR_NO_LF;
          end
        end
        S_LF: begin
          if (byte_i == ChCr) begin
            state_d = S_END_CR;
          end else begin
            res_o.role = ROLE_KEY;
            state_d    = S_KEY;
          end
        end
        S_END_CR: begin
          if (byte_i == ChLf) begin
            res_o.headers_done = 1'b1;
            state_d            = S_START;
          end else begin
            err_d = ERR_CR_NO_LF;
          end
        end
        default: begin
          if (byte_i != ChCr && byte_i != ChLf) begin
            res_o.role = ROLE_KEY;
            state_d    = S_KEY;
          end else begin
            state_d = S_START;
          end
        end
      endcase
    end
    res_o.err_code = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      off_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (adv_i) begin
      state_q <= state_d;
      off_q   <= off_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/http_header_line_parser_core.sv -----
// Top level of the HTTP header line parser: input beat register, parser, result register.
//
//  channel  | dir | beat payload
//  ---------+-----+------------------------------------------------------------
//  hdr_i    | in  | byte_in, restart
//  res_o    | out | byte_out, role, key_done, line_done, headers_done, error,
//           |     | error_code
//  cfg_i    | in  | data = max_value_offset (12 bits, always ready)
//
// One beat per cycle sustained while res_o is ready; a byte passes the input and result registers to res_o.
// The parser state advances as a beat moves from the input register to the result
// register, so consecutive bytes see each other's state with no bubble.
// A stalled res_o holds its beat; one more beat waits in the input register.
// Reset returns the parser to the start state, clears the error and loads 255.
module http_header_line_parser_core (
  input logic        clk_i,
  input logic        rst_ni,
  hhlp_in_if.sink    hdr_i,
  hhlp_out_if.source res_o,
  hhlp_cfg_if.sink   cfg_i
);
  import hhlp_pkg::*;

  logic               in_vld_q;
  logic [ByteW-1:0]   byte_q;
  logic               restart_q;
  logic               out_vld_q;
  hhlp_res_t          res_q, res_d;
  logic [OffsetW-1:0] max_off_q;
  logic               adv;

  assign adv         = in_vld_q && (!out_vld_q || res_o.ready);
  assign hdr_i.ready = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  hhlp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .byte_i    (byte_q),
    .restart_i (restart_q),
    .max_off_i (max_off_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      max_off_q <= MaxOffsetRst;
    end else begin
      if (hdr_i.ready) begin
        in_vld_q <= hdr_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        max_off_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_i.valid && hdr_i.ready) begin
      byte_q    <= hdr_i.byte_in;
      restart_q <= hdr_i.restart;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.byte_out     = res_q.byte_out;
  assign res_o.role         = res_q.role;
  assign res_o.key_done     = res_q.key_done;
  assign res_o.line_done    = res_q.line_done;
  assign res_o.headers_done = res_q.headers_done;
  assign res_o.error        = res_q.err_code != ERR_NONE;
  assign res_o.error_code   = res_q.err_code;

`ifndef NO_ASSERTIONS
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> $onehot0({res_o.key_done, res_o.line_done, res_o.headers_done}))
    else $error("more than one done flag on a result beat");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.error) |->
      (res_o.role == ROLE_SEP && !res_o.key_done && !res_o.line_done &&
       !res_o.headers_done))
    else $error("error beat carries a role or done flag");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_q.err_code != ERR_NONE && out_vld_q && !restart_q) |=>
      (res_q.err_code == $past(res_q.err_code)))
    else $error("error code changed without restart");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the HTTP header line parser: paced byte stream, scoreboard, limit sweeps.
module testbench;
  import hhlp_pkg::*;

  localparam int unsigned CycleLimit  = 800000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned ReportMax   = 10;

  typedef enum logic [3:0] {
    PS_START, PS_KEY, PS_COLON, PS_SPACE, PS_VALUE, PS_CR, PS_LF, PS_END_CR
  } parse_st_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    role_e            role;
    logic             key_done;
    logic             line_done;
    logic             headers_done;
    logic             error;
    err_e             error_code;
  } tag_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             restart;
  } beat_t;

  class header_scoreboard;
    parse_st_e          state;
    logic [OffsetW-1:0] offset;
    err_e               err;
    logic [OffsetW-1:0] max_offset;
    tag_t               tags_q[$];
    int unsigned        mismatches;

    function new();
      state      = PS_START;
      offset     = '0;
      err        = ERR_NONE;
      max_offset = MaxOffsetRst;
      mismatches = 0;
    endfunction

    function void set_max_offset(logic [OffsetW-1:0] v);
      max_offset = v;
    endfunction

    function bit in_error();
      return err != ERR_NONE;
    endfunction

    function int pending();
      return tags_q.size();
    endfunction

    function void note_beat(beat_t bt);
      tag_t           t;
      logic [OffsetW:0] nxt;
      t.data         = bt.data;
      t.role         = ROLE_SEP;
      t.key_done     = 1'b0;
      t.line_done    = 1'b0;
      t.headers_done = 1'b0;
      if (bt.restart) begin
        state  = PS_START;
        offset = '0;
        err    = ERR_NONE;
      end
      if (err == ERR_NONE) begin
        case (state)
          PS_KEY: begin
            if (bt.data == ChColon) begin
              t.key_done = 1'b1;
              state      = PS_COLON;
            end else if (bt.data == ChCr || bt.data == ChLf) begin
              err = ERR_KEY_BRK;
            end else begin
              t.role = ROLE_KEY;
            end
          end
          PS_COLON: begin
            if (bt.data == ChSpace) state = PS_SPACE;
            else err = ERR_NO_SPACE;
          end
          PS_SPACE: begin
            t.role = ROLE_VALUE;
            offset = '0;
            state  = PS_VALUE;
          end
          PS_VALUE: begin
            if (bt.data == ChCr) begin
              state = PS_CR;
            end else begin
              nxt = {1'b0, offset} + 1'b1;
              if (nxt > {1'b0, max_offset}) err = ERR_VAL_LONG;
              else t.role = ROLE_VALUE;
              offset = (nxt > {1'b0, OffsetMax}) ? OffsetMax : nxt[OffsetW-1:0];
            end
          end
          PS_CR: begin
            if (bt.data == ChLf) begin
              t.line_done = 1'b1;
              state       = PS_LF;
            end else begin
              err = ERR_CR_NO_LF;
            end
          end
          PS_LF: begin
            if (bt.data == ChCr) begin
              state = PS_END_CR;
            end else begin
              t.role = ROLE_KEY;
              state  = PS_KEY;
            end
          end
          PS_END_CR: begin
            if (bt.data == ChLf) begin
              t.headers_done = 1'b1;
              state          = PS_START;
            end else begin
              err = ERR_CR_NO_LF;
            end
          end
          default: begin
            if (bt.data != ChCr && bt.data != ChLf) begin
              t.role = ROLE_KEY;
              state  = PS_KEY;
            end else begin
              state = PS_START;
            end
          end
        endcase
      end
      t.error      = (err != ERR_NONE);
      t.error_code = err;
      tags_q.push_back(t);
    endfunction

    function void flag(string what, tag_t want, tag_t got);
      mismatches++;
      if (mismatches <= ReportMax) begin
        $display("%s: exp byte=%h role=%0d kd=%b ld=%b hd=%b err=%b code=%0d", what,
                 want.data, want.role, want.key_done, want.line_done, want.headers_done,
                 want.error, want.error_code);
        $display("    got byte=%h role=%0d kd=%b ld=%b hd=%b err=%b code=%0d",
                 got.data, got.role, got.key_done, got.line_done, got.headers_done,
                 got.error, got.error_code);
      end
    endfunction

    function void check_result(tag_t got);
      tag_t want;
      if (tags_q.size() == 0) begin
        want = '0;
        flag("unexpected beat", want, got);
        return;
      end
      want = tags_q.pop_front();
      if (got.data !== want.data || got.role !== want.role ||
          got.key_done !== want.key_done || got.line_done !== want.line_done ||
          got.headers_done !== want.headers_done || got.error !== want.error ||
          got.error_code !== want.error_code) begin
        flag("mismatch", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hhlp_in_if  hdr_if ();
  hhlp_out_if res_if ();
  hhlp_cfg_if cfg_if ();

  http_header_line_parser_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hdr_i (hdr_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  header_scoreboard sb = new();
  beat_t            beats_q[$];
  bit               hold_req;
  int unsigned      burst_left;
  int unsigned      cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles <= CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned stall_pct;
    int unsigned span;
    int unsigned hold_left;
    tag_t        got;
    stall_pct = 0;
    span      = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.data         = res_if.byte_out;
        got.role         = role_e'(res_if.role);
        got.key_done     = res_if.key_done;
        got.line_done    = res_if.line_done;
        got.headers_done = res_if.headers_done;
        got.error        = res_if.error;
        got.error_code   = err_e'(res_if.error_code);
        sb.check_result(got);
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (span == 0) begin
        span      = $urandom_range(120, 20);
        stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(80);
      end
      span--;
      res_if.ready <= rst_ni && hold_left == 0 && $urandom_range(99) >= stall_pct;
    end
  end

  function automatic void push(logic [ByteW-1:0] b, bit rs = 1'b0);
    beat_t bt;
    bt.data    = b;
    bt.restart = rs;
    beats_q.push_back(bt);
  endfunction

  function automatic logic [ByteW-1:0] key_char();
    logic [ByteW-1:0] b;
    if ($urandom_range(3) == 0) begin
      do b = ByteW'($urandom_range(255)); while (b == ChCr || b == ChLf || b == ChColon);
    end else begin
      do b = ByteW'($urandom_range(8'h7e, 8'h21)); while (b == ChColon);
    end
    return b;
  endfunction

  function automatic logic [ByteW-1:0] value_char();
    logic [ByteW-1:0] b;
    if ($urandom_range(4) == 0) begin
      do b = ByteW'($urandom_range(255)); while (b == ChCr);
    end else begin
      b = ByteW'($urandom_range(8'h7e, 8'h20));
    end
    return b;
  endfunction

  function automatic void add_line(int unsigned vlen);
    repeat ($urandom_range(10, 1)) push(key_char());
    push(ChColon);
    push(ChSpace);
    repeat (vlen) push(value_char());
    push(ChCr);
    push(ChLf);
  endfunction

  function automatic int unsigned value_len(logic [OffsetW-1:0] lim);
    if (lim <= 40 && $urandom_range(9) < 3) return lim + $urandom_range(2);
    return $urandom_range(12, 1);
  endfunction

  function automatic void add_block(logic [OffsetW-1:0] lim);
    int unsigned n0;
    int unsigned pos;
    int unsigned kind;
    n0   = beats_q.size();
    kind = $urandom_range(19);
    if (kind < 2) begin
      repeat ($urandom_range(8, 1)) push(ByteW'($urandom_range(255)), $urandom_range(9) == 0);
    end else begin
      repeat ($urandom_range(2)) push($urandom_range(1) ? ChCr : ChLf);
      repeat ($urandom_range(4, 1)) add_line(value_len(lim));
      push(ChCr);
      push(ChLf);
      if (kind < 5) begin
        pos = $urandom_range(beats_q.size() - 1, n0);
        case ($urandom_range(3))
          0: beats_q[pos].data = ByteW'($urandom_range(255));
          1: beats_q[pos].data = $urandom_range(1) ? ChCr : ChLf;
          2: beats_q[pos].restart = 1'b1;
          default: begin
            while (beats_q.size() > pos) void'(beats_q.pop_back());
          end
        endcase
      end
    end
    if (beats_q.size() > n0 && (sb.in_error() || $urandom_range(3) == 0)) begin
      beats_q[n0].restart = 1'b1;
    end
  endfunction

  task automatic drive_beats();
    beat_t bt;
    while (beats_q.size() != 0) begin
      bt = beats_q.pop_front();
      hdr_if.valid   <= 1'b1;
      hdr_if.byte_in <= bt.data;
      hdr_if.restart <= bt.restart;
      do @(posedge clk_i); while (!hdr_if.ready);
      sb.note_beat(bt);
      if (burst_left == 0) begin
        hdr_if.valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 60) : $urandom_range(30);
      end else begin
        burst_left--;
      end
    end
    hdr_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_max_offset(logic [OffsetW-1:0] v);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_max_offset(v);
  endtask

  task automatic run_phase(logic [OffsetW-1:0] lim, int unsigned n_items, bit hold_off);
    int unsigned sent;
    write_max_offset(lim);
    if (hold_off) hold_req = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      add_block(lim);
      sent += beats_q.size();
      drive_beats();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    hdr_if.valid   <= 1'b0;
    hdr_if.byte_in <= '0;
    hdr_if.restart <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.data    <= '0;
    hold_req   = 1'b0;
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // skipped line breaks, colon as first key byte, line breaks as first value bytes
    push(ChCr, 1'b1);
    push(ChLf);
    push(ChColon);
    push(8'hff);
    push(ChColon);
    push(ChSpace);
    push(ChCr);
    push(ChLf);
    push(8'h00);
    push(ChCr);
    push(ChLf);
    // LF opens the next key, then the blank line ends the block
    push(ChLf);
    push("k");
    push(ChColon);
    push(ChSpace);
    push("v");
    push(ChCr);
    push(ChLf);
    push(ChCr);
    push(ChLf);
    // line break in key, then no space after the colon
    push("a", 1'b1);
    push(ChCr);
    push("a", 1'b1);
    push(ChColon);
    push("x");
    drive_beats();

    run_phase(MaxOffsetRst, 100, 1'b0);
    run_phase(12'd0, 100, 1'b0);
    run_phase(12'd1, 100, 1'b1);
    run_phase(OffsetMax, 100, 1'b0);
    run_phase(12'd2, 100, 1'b0);
    run_phase(OffsetW'($urandom_range(40, 3)), 100, 1'b0);
    run_phase(OffsetW'($urandom_range(4094, 41)), 100, 1'b1);
    run_phase(MaxOffsetRst, 60, 1'b0);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hhlp_pkg.sv
rtl/hhlp_if.sv
rtl/hhlp_parser.sv
rtl/http_header_line_parser_core.sv
tb/testbench.sv
